[hw/rtl/lpd_pkg.sv]
`timescale 1ns / 1ps

package lpd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SECTION = 2'd1,
    PH_DATA    = 2'd2
  } phase_t;

  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // Byte offsets of the fields within the descriptor section.
  localparam logic [IDX_W-1:0] OFS_LEN_LO = 4'd0;
  localparam logic [IDX_W-1:0] OFS_LEN_HI = 4'd1;
  localparam logic [IDX_W-1:0] OFS_OPT_LO = 4'd2;
  localparam logic [IDX_W-1:0] OFS_OPT_HI = 4'd3;
  localparam logic [IDX_W-1:0] OFS_SND_LO = 4'd4;
  localparam logic [IDX_W-1:0] OFS_SND_HI = 4'd5;
  localparam logic [IDX_W-1:0] OFS_SRC_B0 = 4'd6;
  localparam logic [IDX_W-1:0] OFS_SRC_B1 = 4'd7;
  localparam logic [IDX_W-1:0] OFS_SRC_B2 = 4'd8;
  localparam logic [IDX_W-1:0] OFS_SRC_B3 = 4'd9;

  typedef struct packed {
    logic [7:0]         payload_byte;
    logic [15:0]        pkt_option;
    logic [15:0]        packet_sender;
    logic signed [31:0] source_id;
    logic               is_last;
    logic               empty_packet;
  } result_t;

endpackage

[hw/rtl/length_prefixed_packet_deframer.sv]
`timescale 1ns / 1ps
// A result word is written into the queue when its input byte is taken, then moves to the output register.
// Throughput: one byte per cycle while the queue is not full (in_stall low); the parser updates its phase per byte.
// A queue of QUEUE_DEPTH words plus the output register absorbs output stalls.
// Reset (rst, synchronous, active high) returns the parser to the header phase,
// clears the captured fields and empties the queue and output register.

module length_prefixed_packet_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         payload_byte,
  output logic [15:0]        pkt_option,
  output logic [15:0]        packet_sender,
  output logic signed [31:0] source_id,
  output logic               is_last,
  output logic               empty_packet
);

  logic             push, pop, full, not_empty;
  lpd_pkg::result_t rec, head;

  assign in_stall = full;

  lpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .push     (push),
    .rec      (rec)
  );

  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rec),
    .pop       (pop),
    .pop_data  (head),
    .full      (full),
    .not_empty (not_empty)
  );

  lpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (not_empty),
    .head          (head),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .payload_byte  (payload_byte),
    .pkt_option    (pkt_option),
    .packet_sender (packet_sender),
    .source_id     (source_id),
    .is_last       (is_last),
    .empty_packet  (empty_packet)
  );

endmodule

[hw/rtl/lpd_front.sv]
`timescale 1ns / 1ps

module lpd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             push,
  output lpd_pkg::result_t rec
);

  lpd_pkg::phase_t               phase, phase_next;
  logic [7:0]                    section_left, section_left_next;
  logic [lpd_pkg::IDX_W-1:0]     section_index, section_index_next;
  logic [15:0]                   payload_left, payload_left_next;
  logic [15:0]                   captured_length, captured_length_next;
  logic [15:0]                   captured_option, captured_option_next;
  logic [15:0]                   captured_sender, captured_sender_next;
  logic [31:0]                   captured_source, captured_source_next;

  logic [15:0] cap_length, cap_option, cap_sender;
  logic [31:0] cap_source;
  logic [7:0]  left_dec;
  logic [15:0] payload_dec;
  logic        accept;
  logic        emit;

  assign accept      = in_valid && !in_stall;
  assign left_dec    = section_left - 8'd1;
  assign payload_dec = payload_left - 16'd1;
  assign push        = accept && emit;

  // The descriptor byte at the current index lands in its field.
  always_comb begin
    cap_length = captured_length;
    cap_option = captured_option;
    cap_sender = captured_sender;
    cap_source = captured_source;
    case (section_index)
      lpd_pkg::OFS_LEN_LO: cap_length[7:0]   = rx_byte;
      lpd_pkg::OFS_LEN_HI: cap_length[15:8]  = rx_byte;
      lpd_pkg::OFS_OPT_LO: cap_option[7:0]   = rx_byte;
      lpd_pkg::OFS_OPT_HI: cap_option[15:8]  = rx_byte;
      lpd_pkg::OFS_SND_LO: cap_sender[7:0]   = rx_byte;
      lpd_pkg::OFS_SND_HI: cap_sender[15:8]  = rx_byte;
      lpd_pkg::OFS_SRC_B0: cap_source[7:0]   = rx_byte;
      lpd_pkg::OFS_SRC_B1: cap_source[15:8]  = rx_byte;
      lpd_pkg::OFS_SRC_B2: cap_source[23:16] = rx_byte;
      lpd_pkg::OFS_SRC_B3: cap_source[31:24] = rx_byte;
      default: ;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      lpd_pkg::PH_SECTION: begin
        if (left_dec == 8'd0) begin
          phase_next = (cap_length == 16'd0) ? lpd_pkg::PH_HEADER : lpd_pkg::PH_DATA;
        end
      end
      lpd_pkg::PH_DATA: begin
        if (payload_dec == 16'd0) begin
          phase_next = lpd_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_next = (rx_byte == 8'd0) ? lpd_pkg::PH_HEADER : lpd_pkg::PH_SECTION;
      end
    endcase
  end

  // Datapath updates and the result word.
  always_comb begin
    section_left_next    = section_left;
    section_index_next   = section_index;
    payload_left_next    = payload_left;
    captured_length_next = captured_length;
    captured_option_next = captured_option;
    captured_sender_next = captured_sender;
    captured_source_next = captured_source;
    emit                 = 1'b0;
    rec.payload_byte     = 8'd0;
    rec.pkt_option       = captured_option;
    rec.packet_sender    = captured_sender;
    rec.source_id        = captured_source;
    rec.is_last          = 1'b0;
    rec.empty_packet     = 1'b0;
    unique case (phase)
      lpd_pkg::PH_SECTION: begin
        captured_length_next = cap_length;
        captured_option_next = cap_option;
        captured_sender_next = cap_sender;
        captured_source_next = cap_source;
        section_index_next   = (section_index == lpd_pkg::IDX_MAX) ?
                               section_index : section_index + 1'b1;
        section_left_next    = left_dec;
        rec.pkt_option       = cap_option;
        rec.packet_sender    = cap_sender;
        rec.source_id        = cap_source;
        if (left_dec == 8'd0) begin
          payload_left_next = cap_length;
          if (cap_length == 16'd0) begin
            emit             = 1'b1;
            rec.is_last      = 1'b1;
            rec.empty_packet = 1'b1;
          end
        end
      end
      lpd_pkg::PH_DATA: begin
        payload_left_next = payload_dec;
        emit              = 1'b1;
        rec.payload_byte  = rx_byte;
        rec.is_last       = (payload_dec == 16'd0);
      end
      default: begin
        // A header byte starts a fresh packet with every field cleared.
        captured_length_next = 16'd0;
        captured_option_next = 16'd0;
        captured_sender_next = 16'd0;
        captured_source_next = 32'd0;
        section_index_next   = '0;
        section_left_next    = rx_byte;
        rec.pkt_option       = 16'd0;
        rec.packet_sender    = 16'd0;
        rec.source_id        = 32'sd0;
        if (rx_byte == 8'd0) begin
          payload_left_next = 16'd0;
          emit              = 1'b1;
          rec.is_last       = 1'b1;
          rec.empty_packet  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lpd_pkg::PH_HEADER;
      section_left    <= 8'd0;
      section_index   <= '0;
      payload_left    <= 16'd0;
      captured_length <= 16'd0;
      captured_option <= 16'd0;
      captured_sender <= 16'd0;
      captured_source <= 32'd0;
    end else if (accept) begin
      phase           <= phase_next;
      section_left    <= section_left_next;
      section_index   <= section_index_next;
      payload_left    <= payload_left_next;
      captured_length <= captured_length_next;
      captured_option <= captured_option_next;
      captured_sender <= captured_sender_next;
      captured_source <= captured_source_next;
    end
  end

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == lpd_pkg::PH_DATA) |-> (payload_left != 16'd0))
    else $error("payload phase entered with no bytes left");

  a_section_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == lpd_pkg::PH_SECTION) |-> (section_left != 8'd0))
    else $error("descriptor phase entered with no bytes left");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (push && rec.empty_packet) |-> (rec.is_last && rec.payload_byte == 8'd0))
    else $error("empty packet word not marked last");

endmodule

[hw/rtl/lpd_queue.sv]
`timescale 1ns / 1ps

module lpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpd_pkg::result_t push_data,
  input  logic             pop,
  output lpd_pkg::result_t pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lpd_pkg::result_t   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("word pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("word popped from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

[hw/rtl/lpd_back.sv]
`timescale 1ns / 1ps

module lpd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               not_empty,
  input  lpd_pkg::result_t   head,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         payload_byte,
  output logic [15:0]        pkt_option,
  output logic [15:0]        packet_sender,
  output logic signed [31:0] source_id,
  output logic               is_last,
  output logic               empty_packet
);

  lpd_pkg::result_t held;

  // The output register reloads from the queue when the queue holds a word and the register is empty or being taken.
  assign pop = not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head;
    end
  end

  assign payload_byte  = held.payload_byte;
  assign pkt_option    = held.pkt_option;
  assign packet_sender = held.packet_sender;
  assign source_id     = held.source_id;
  assign is_last       = held.is_last;
  assign empty_packet  = held.empty_packet;

endmodule

[dv/length_prefixed_packet_deframer_test.sv]
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_test;

  localparam int unsigned RX_TARGET = 1100;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // Predicts the deframed words and checks them in order of arrival.
  class deframe_scoreboard;
    lpd_pkg::phase_t  phase;
    logic [7:0]       section_left;
    logic [7:0]       section_index;
    logic [15:0]      payload_left;
    logic [15:0]      length_field;
    logic [15:0]      option_field;
    logic [15:0]      sender_field;
    logic [31:0]      source_field;
    lpd_pkg::result_t expected_words[$];
    int unsigned      fail_count;

    function new();
      phase = lpd_pkg::PH_HEADER;
      section_left = '0;
      section_index = '0;
      payload_left = '0;
      length_field = '0;
      option_field = '0;
      sender_field = '0;
      source_field = '0;
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [7:0] data, logic last, logic empty);
      lpd_pkg::result_t word;
      word.payload_byte = data;
      word.pkt_option = option_field;
      word.packet_sender = sender_field;
      word.source_id = source_field;
      word.is_last = last;
      word.empty_packet = empty;
      expected_words.push_back(word);
    endfunction

    function void capture_descriptor_byte(logic [7:0] b);
      case (section_index)
        lpd_pkg::OFS_LEN_LO: length_field[7:0] = b;
        lpd_pkg::OFS_LEN_HI: length_field[15:8] = b;
        lpd_pkg::OFS_OPT_LO: option_field[7:0] = b;
        lpd_pkg::OFS_OPT_HI: option_field[15:8] = b;
        lpd_pkg::OFS_SND_LO: sender_field[7:0] = b;
        lpd_pkg::OFS_SND_HI: sender_field[15:8] = b;
        lpd_pkg::OFS_SRC_B0: source_field[7:0] = b;
        lpd_pkg::OFS_SRC_B1: source_field[15:8] = b;
        lpd_pkg::OFS_SRC_B2: source_field[23:16] = b;
        lpd_pkg::OFS_SRC_B3: source_field[31:24] = b;
        default: ;
      endcase
    endfunction

    // A zero payload length closes the packet at once with an empty word.
    function void close_descriptor();
      payload_left = length_field;
      if (payload_left == 16'd0) begin
        phase = lpd_pkg::PH_HEADER;
        push_word(8'h00, 1'b1, 1'b1);
      end else begin
        phase = lpd_pkg::PH_DATA;
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      case (phase)
        lpd_pkg::PH_SECTION: begin
          capture_descriptor_byte(b);
          if (section_index != 8'hFF) section_index++;
          section_left--;
          if (section_left == 8'd0) close_descriptor();
        end
        lpd_pkg::PH_DATA: begin
          payload_left--;
          if (payload_left == 16'd0) phase = lpd_pkg::PH_HEADER;
          push_word(b, payload_left == 16'd0, 1'b0);
        end
        default: begin
          length_field = '0;
          option_field = '0;
          sender_field = '0;
          source_field = '0;
          section_index = '0;
          section_left = b;
          if (b == 8'd0) close_descriptor();
          else phase = lpd_pkg::PH_SECTION;
        end
      endcase
    endfunction

    function void check_word(lpd_pkg::result_t got);
      lpd_pkg::result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, got);
        fail_count++;
        return;
      end
      want = expected_words.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload_byte expected %h got %h", $time, want.payload_byte,
                 got.payload_byte);
        fail_count++;
      end
      if (got.pkt_option !== want.pkt_option) begin
        $display("%0t: pkt_option expected %h got %h", $time, want.pkt_option,
                 got.pkt_option);
        fail_count++;
      end
      if (got.packet_sender !== want.packet_sender) begin
        $display("%0t: packet_sender expected %h got %h", $time, want.packet_sender,
                 got.packet_sender);
        fail_count++;
      end
      if (got.source_id !== want.source_id) begin
        $display("%0t: source_id expected %h got %h", $time, want.source_id, got.source_id);
        fail_count++;
      end
      if (got.is_last !== want.is_last) begin
        $display("%0t: is_last expected %b got %b", $time, want.is_last, got.is_last);
        fail_count++;
      end
      if (got.empty_packet !== want.empty_packet) begin
        $display("%0t: empty_packet expected %b got %b", $time, want.empty_packet,
                 got.empty_packet);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         payload_byte;
  logic [15:0]        pkt_option;
  logic [15:0]        packet_sender;
  logic signed [31:0] source_id;
  logic               is_last;
  logic               empty_packet;

  deframe_scoreboard  sb = new();
  lpd_pkg::result_t   seen_word;
  int unsigned        rx_count = 0;
  int unsigned        cycle_count = 0;
  bit                 hold_request = 1'b0;

  length_prefixed_packet_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .pkt_option   (pkt_option),
    .packet_sender(packet_sender),
    .source_id    (source_id),
    .is_last      (is_last),
    .empty_packet (empty_packet)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no pause, now and then a short one, rarely a long one.
  function automatic int unsigned random_pause(int unsigned long_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_rx_byte(rx_byte);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_word.payload_byte = payload_byte;
      seen_word.pkt_option = pkt_option;
      seen_word.packet_sender = packet_sender;
      seen_word.source_id = source_id;
      seen_word.is_last = is_last;
      seen_word.empty_packet = empty_packet;
      sb.check_word(seen_word);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  initial begin
    int unsigned run;
    int unsigned hold;
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : 1 + random_pause(20);
      repeat (run) @(posedge clk);
      hold = random_pause(40);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input bit quiet);
    int unsigned gap;
    in_valid <= 1'b1;
    rx_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = quiet ? 0 : random_pause(30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One framed packet: header, descriptor of random size, then the payload it announces.
  task automatic send_packet();
    int unsigned section_len;
    int unsigned length_value;
    int unsigned pick;
    int unsigned data_len;
    logic [7:0]  fields[10];
    bit          quiet;
    quiet = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 6) section_len = 0;
    else if (pick < 26) section_len = $urandom_range(1, 9);
    else if (pick < 80) section_len = 10;
    else if (pick < 97) section_len = $urandom_range(11, 24);
    else section_len = $urandom_range(100, 255);
    pick = $urandom_range(0, 99);
    if (pick < 10) length_value = 0;
    else if (pick < 80) length_value = $urandom_range(1, 8);
    else if (pick < 95) length_value = $urandom_range(9, 40);
    else length_value = $urandom_range(256, 300);
    fields[0] = length_value[7:0];
    fields[1] = length_value[15:8];
    pick = $urandom_range(0, 9);
    for (int i = 2; i < 10; i++) begin
      if (pick == 0) fields[i] = 8'hFF;
      else if (pick == 1) fields[i] = 8'h00;
      else fields[i] = 8'($urandom_range(0, 255));
    end
    // Descriptor bytes that never arrive read as zero.
    if (section_len == 0) data_len = 0;
    else if (section_len == 1) data_len = length_value & 32'hFF;
    else data_len = length_value;
    send_byte(section_len[7:0], quiet);
    for (int i = 0; i < section_len; i++)
      send_byte((i < 10) ? fields[i] : 8'($urandom_range(0, 255)), quiet);
    for (int i = 0; i < data_len; i++) send_byte(8'($urandom_range(0, 255)), quiet);
    rx_count += 1 + section_len + data_len;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [7:0] directed_bytes[$];
    int unsigned packet_no;
    // Empty header, a one-byte descriptor with zero length, a long descriptor with
    // saturated fields and a negative source id, then a short one missing most fields.
    directed_bytes = '{8'h00,
                       8'h01, 8'h00,
                       8'h0C, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'h00, 8'h00, 8'h00, 8'h80, 8'h5A, 8'hA5, 8'hFF,
                       8'h03, 8'h02, 8'h00, 8'hAA, 8'h00, 8'h7F};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b0);
    rx_count = directed_bytes.size();
    packet_no = 0;
    hold_request = 1'b1;
    while (rx_count < RX_TARGET) begin
      if (packet_no == 30) hold_request = 1'b1;
      send_packet();
      packet_no++;
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
